[hdl/sbas_pkg.sv]
// Package of the safety button arming sequencer: configuration and result
// structures, register indexes, window limits and event codes.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package sbas_pkg;

   // Tick counter and its windows
   localparam int unsigned COUNT_W = 8;
   localparam logic [COUNT_W-1:0] FIRST_WINDOW  = 8'd30;
   localparam logic [COUNT_W-1:0] SECOND_WINDOW = 8'd60;
   localparam logic [COUNT_W-1:0] RESET_WINDOW  = 8'd150;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT   = 8'd255;

   // Blink step runs over 48 steps, three per pattern bit
   localparam int unsigned STEP_W = 6;
   localparam logic [STEP_W-1:0] STEP_LAST = 6'd47;
   // Reciprocal of three, exact for steps below 48
   localparam logic [6:0] THIRD_MUL   = 7'd43;
   localparam int unsigned THIRD_SHIFT = 7;

   // Configuration port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUTTON_ENABLED  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AIRFRAME_KIND   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFUSE_PATTERN  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_PATTERN    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAFE_PATTERN    = 3'd5;
   localparam logic [11:0] PRESS_THRESHOLD_RESET = 12'h200;

   // Airframe kinds
   localparam logic [1:0] AIRFRAME_NONE       = 2'd0;
   localparam logic [1:0] AIRFRAME_MULTIROTOR = 2'd1;
   localparam logic [1:0] AIRFRAME_AIRPLANE   = 2'd2;

   // Beep events
   localparam logic [1:0] BEEP_NONE = 2'd0;
   localparam logic [1:0] BEEP_INIT = 2'd1;
   localparam logic [1:0] BEEP_SAFE = 2'd2;
   localparam logic [1:0] BEEP_FAIL = 2'd3;

   // Motor commands
   localparam logic [1:0] MOTOR_NONE      = 2'd0;
   localparam logic [1:0] MOTOR_MIN_PULSE = 2'd1;
   localparam logic [1:0] MOTOR_DISABLE   = 2'd2;

   typedef struct packed {
      logic        button_enabled;
      logic [1:0]  airframe_kind;
      logic [11:0] press_threshold;
      logic [15:0] refuse_pattern;
      logic [15:0] init_pattern;
      logic [15:0] safe_pattern;
   } cfg_type;

   typedef struct packed {
      logic       safe_to_output;
      logic [1:0] motor_command;
      logic [1:0] beep_event;
      logic       led_on;
   } result_type;

endpackage

`default_nettype wire

[hdl/sbas_csr.sv]
// Configuration register file of the safety button arming sequencer.
// Depends on sbas_pkg for the register indexes and the cfg_type structure.
`default_nettype none

module sbas_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sbas_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sbas_pkg::CSR_DATA_W-1:0]   csr_data,
   output sbas_pkg::cfg_type                      cfg
);

   sbas_pkg::cfg_type cfg_ff;
   sbas_pkg::cfg_type cfg_in;

   // Always ready for a write transaction
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            sbas_pkg::CSR_BUTTON_ENABLED:  cfg_in.button_enabled  = csr_data[0];
            sbas_pkg::CSR_AIRFRAME_KIND:   cfg_in.airframe_kind   = csr_data[1:0];
            sbas_pkg::CSR_PRESS_THRESHOLD: cfg_in.press_threshold = csr_data[11:0];
            sbas_pkg::CSR_REFUSE_PATTERN:  cfg_in.refuse_pattern  = csr_data;
            sbas_pkg::CSR_INIT_PATTERN:    cfg_in.init_pattern    = csr_data;
            sbas_pkg::CSR_SAFE_PATTERN:    cfg_in.safe_pattern    = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.button_enabled  <= 1'b0;
         cfg_ff.airframe_kind   <= sbas_pkg::AIRFRAME_NONE;
         cfg_ff.press_threshold <= sbas_pkg::PRESS_THRESHOLD_RESET;
         cfg_ff.refuse_pattern  <= 16'h0000;
         cfg_ff.init_pattern    <= 16'h0000;
         cfg_ff.safe_pattern    <= 16'h0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[hdl/sbas_step.sv]
// Sequencer state and the single-pass step logic for one tick.
// Depends on sbas_pkg for window limits, codes and structures.
`default_nettype none

module sbas_step (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_fire,
   input  wire logic [11:0]       button_sample,
   input  wire logic              armed,
   input  wire sbas_pkg::cfg_type cfg,
   output sbas_pkg::result_type   result
);

   logic [sbas_pkg::COUNT_W-1:0] tick_count_ff, tick_count_in;
   logic                         wait_flag_ff, wait_flag_in;
   logic                         safe_flag_ff, safe_flag_in;
   logic [sbas_pkg::STEP_W-1:0]  blink_step_ff, blink_step_in;
   logic [15:0]                  current_pattern_ff, current_pattern_in;
   logic                         led_level_ff, led_level_in;

   logic                         pressed;
   logic                         motors;
   logic [sbas_pkg::COUNT_W-1:0] count;
   logic [12:0]                  step_prod;
   logic [3:0]                   bit_index;

   assign pressed   = button_sample <= cfg.press_threshold;
   assign motors    = (cfg.airframe_kind == sbas_pkg::AIRFRAME_MULTIROTOR) ||
                      (cfg.airframe_kind == sbas_pkg::AIRFRAME_AIRPLANE);
   // Pattern bit is blink_step / 3
   assign step_prod = 13'(blink_step_ff) * 13'(sbas_pkg::THIRD_MUL);
   assign bit_index = step_prod[sbas_pkg::THIRD_SHIFT +: 4];

   // Work out one tick
   always_comb begin
      tick_count_in      = tick_count_ff;
      wait_flag_in       = wait_flag_ff;
      safe_flag_in       = safe_flag_ff;
      blink_step_in      = blink_step_ff;
      current_pattern_in = current_pattern_ff;
      led_level_in       = led_level_ff;
      count              = tick_count_ff;

      result.led_on         = led_level_ff;
      result.beep_event     = sbas_pkg::BEEP_NONE;
      result.motor_command  = sbas_pkg::MOTOR_NONE;
      result.safe_to_output = cfg.button_enabled ? safe_flag_ff : 1'b1;

      if (cfg.button_enabled && !armed) begin
         if (count < sbas_pkg::FIRST_WINDOW) begin
            current_pattern_in = cfg.refuse_pattern;
         end else if (count > sbas_pkg::FIRST_WINDOW && count < sbas_pkg::SECOND_WINDOW) begin
            // Init-arm window
            current_pattern_in = cfg.init_pattern;
            if (count == sbas_pkg::FIRST_WINDOW + 8'd1) begin
               result.beep_event = sbas_pkg::BEEP_INIT;
            end
            if (pressed) begin
               wait_flag_in = 1'b1;
               if (motors) begin
                  result.motor_command = sbas_pkg::MOTOR_MIN_PULSE;
               end
            end else if (!wait_flag_ff) begin
               count = sbas_pkg::FIRST_WINDOW + 8'd1;
            end
         end else if (count > sbas_pkg::SECOND_WINDOW && count < sbas_pkg::RESET_WINDOW) begin
            // Safe-to-arm window; wait flag cleared on entry
            current_pattern_in = cfg.safe_pattern;
            if (count == sbas_pkg::SECOND_WINDOW + 8'd1) begin
               result.beep_event = sbas_pkg::BEEP_SAFE;
               wait_flag_in      = 1'b0;
            end
            if (pressed) begin
               wait_flag_in = 1'b1;
               safe_flag_in = 1'b1;
            end else if (!wait_flag_in) begin
               count = sbas_pkg::SECOND_WINDOW + 8'd1;
            end
         end else if (count > sbas_pkg::RESET_WINDOW) begin
            // Reset zone
            if (count == sbas_pkg::RESET_WINDOW + 8'd1) begin
               result.beep_event = sbas_pkg::BEEP_FAIL;
               wait_flag_in      = 1'b0;
            end else if (pressed) begin
               count        = '0;
               safe_flag_in = 1'b0;
               if (motors) begin
                  result.motor_command = sbas_pkg::MOTOR_DISABLE;
               end
            end else begin
               count = sbas_pkg::COUNT_LIMIT - 8'd2;
            end
         end

         // Blink the LED from the pattern in use
         led_level_in  = current_pattern_in[bit_index];
         blink_step_in = (blink_step_ff == sbas_pkg::STEP_LAST) ? '0 : blink_step_ff + 6'd1;

         // Advance the saturating counter while released
         if (!pressed && count < sbas_pkg::COUNT_LIMIT) begin
            count = count + 8'd1;
         end
         tick_count_in = count;

         result.led_on         = led_level_in;
         result.safe_to_output = safe_flag_in;
      end
   end

   // Commit state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff      <= '0;
         wait_flag_ff       <= 1'b0;
         safe_flag_ff       <= 1'b0;
         blink_step_ff      <= '0;
         current_pattern_ff <= '0;
         led_level_ff       <= 1'b0;
      end else if (step_fire) begin
         tick_count_ff      <= tick_count_in;
         wait_flag_ff       <= wait_flag_in;
         safe_flag_ff       <= safe_flag_in;
         blink_step_ff      <= blink_step_in;
         current_pattern_ff <= current_pattern_in;
         led_level_ff       <= led_level_in;
      end
   end

endmodule

`default_nettype wire

[hdl/safety_button_arming_sequencer.sv]
// Top level of the safety button arming sequencer: stream ports, register
// file, step logic and the result register. Depends on sbas_pkg, sbas_csr
// and sbas_step.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  req_tdata[15:0]  one tick
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata[7:0]   one result
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// The step logic runs from the request port into the result register, and
// a tick is taken every cycle while the result register is empty or being
// drained in the same cycle.
// Reset is synchronous; it clears the sequencer state, the registers to their
// defaults and the result valid flag. A stalled result holds its data and
// blocks further ticks until it is taken.
`default_nettype none

module safety_button_arming_sequencer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // [11:0] button_sample, [12] armed, [15:13] zero
   input  wire logic [15:0]                       req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [0] led_on, [2:1] beep_event, [4:3] motor_command, [5] safe_to_output,
   // [7:6] zero
   output logic [7:0]                             rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sbas_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [sbas_pkg::CSR_DATA_W-1:0]   csr_data
);

   sbas_pkg::cfg_type    cfg;
   sbas_pkg::result_type result;
   sbas_pkg::result_type rsp_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_fire;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   sbas_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sbas_step u_step (
      .clock         (clock),
      .reset         (reset),
      .step_fire     (req_fire),
      .button_sample (req_tdata[11:0]),
      .armed         (req_tdata[12]),
      .cfg           (cfg),
      .result        (result)
   );

   // Hold the result until the downstream takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

   // An accepted tick always yields a result in the next cycle
   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("accepted tick produced no result");

   // Disabled or armed ticks issue neither beep nor motor command
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (!cfg.button_enabled || req_tdata[12])) |=> (rsp_tdata[4:1] == 4'd0))
      else $error("beep or motor command while disabled or armed");

   // No motor command without a motor-driving airframe
   a_no_motor_kind: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !(cfg.airframe_kind == sbas_pkg::AIRFRAME_MULTIROTOR ||
                     cfg.airframe_kind == sbas_pkg::AIRFRAME_AIRPLANE))
      |=> (rsp_tdata[4:3] == sbas_pkg::MOTOR_NONE))
      else $error("motor command issued for an airframe without motors");

endmodule

`default_nettype wire

[test/safety_button_arming_sequencer_tb.sv]
`timescale 1ns / 1ps
// Testbench of the safety button arming sequencer: walks ticks through the arming
// windows under several register settings and checks every indication field by field.
// Depends on sbas_pkg and safety_button_arming_sequencer.
module safety_button_arming_sequencer_tb;
   import sbas_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int REPORT_LIMIT     = 10;
   localparam int LONG_HOLD_AT     = 100;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam logic [1:0] AIRFRAME_UNKNOWN = 2'd3;

   typedef struct packed {
      logic        armed;
      logic [11:0] sample;
   } tick_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [15:0]            req_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // Shadow registers and sequencer state
   cfg_type     arm_cfg = '{1'b0, AIRFRAME_NONE, PRESS_THRESHOLD_RESET, 16'h0, 16'h0, 16'h0};
   int unsigned dwell         = 0;
   int unsigned blink_phase   = 0;
   logic        hold_seen     = 1'b0;
   logic        safe_latched  = 1'b0;
   logic [15:0] shown_pattern = '0;
   logic        lamp          = 1'b0;

   // Stimulus and checking state
   tick_type   tick_backlog[$];
   tick_type   shown_tick;
   result_type awaited_indications[$];
   int         send_gap = 0;
   int         recv_gap = 0;
   int         hold_left = 0;
   bit         long_hold_done = 1'b0;
   bit         calm = 1'b0;
   int         ticks_accepted = 0;
   int         indications_checked = 0;
   int         mismatch_count = 0;
   int         cycle_count = 0;

   safety_button_arming_sequencer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Advance the shadow sequencer by one tick and return the indication it gives
   function automatic result_type sequencer_step(tick_type t);
      result_type  ind;
      int unsigned c;
      logic        pressed;
      logic        motors;
      ind = '0;
      ind.beep_event    = BEEP_NONE;
      ind.motor_command = MOTOR_NONE;
      // switched off or armed: freeze everything, repeat the LED level
      if (!arm_cfg.button_enabled || t.armed) begin
         ind.led_on         = lamp;
         ind.safe_to_output = arm_cfg.button_enabled ? safe_latched : 1'b1;
         return ind;
      end
      pressed = (t.sample <= arm_cfg.press_threshold);
      motors  = (arm_cfg.airframe_kind == AIRFRAME_MULTIROTOR) ||
                (arm_cfg.airframe_kind == AIRFRAME_AIRPLANE);
      c = dwell;
      if (c < FIRST_WINDOW) begin
         shown_pattern = arm_cfg.refuse_pattern;
      end else if (c > FIRST_WINDOW && c < SECOND_WINDOW) begin
         shown_pattern = arm_cfg.init_pattern;
         if (c == FIRST_WINDOW + 1)
            ind.beep_event = BEEP_INIT;
         if (pressed) begin
            hold_seen = 1'b1;
            if (motors)
               ind.motor_command = MOTOR_MIN_PULSE;
         end else if (!hold_seen) begin
            c = FIRST_WINDOW + 1;
         end
      end else if (c > SECOND_WINDOW && c < RESET_WINDOW) begin
         shown_pattern = arm_cfg.safe_pattern;
         if (c == SECOND_WINDOW + 1) begin
            ind.beep_event = BEEP_SAFE;
            hold_seen = 1'b0;
         end
         if (pressed) begin
            hold_seen    = 1'b1;
            safe_latched = 1'b1;
         end else if (!hold_seen) begin
            c = SECOND_WINDOW + 1;
         end
      end else if (c > RESET_WINDOW) begin
         // reset zone: fail beep on entry, then a press restarts, a release parks
         if (c == RESET_WINDOW + 1) begin
            ind.beep_event = BEEP_FAIL;
            hold_seen = 1'b0;
         end else if (pressed) begin
            c = 0;
            if (motors)
               ind.motor_command = MOTOR_DISABLE;
            safe_latched = 1'b0;
         end else begin
            c = COUNT_LIMIT - 2;
         end
      end
      // three steps per pattern bit, 48 steps per sweep
      lamp = shown_pattern[blink_phase / 3];
      blink_phase = (blink_phase == STEP_LAST) ? 0 : blink_phase + 1;
      if (!pressed && c < COUNT_LIMIT)
         c++;
      dwell = c;
      ind.led_on         = lamp;
      ind.safe_to_output = safe_latched;
      return ind;
   endfunction

   function automatic tick_type pressed_tick(int unsigned thr);
      tick_type t;
      t.armed  = 1'b0;
      t.sample = 12'($urandom_range(thr, 0));
      return t;
   endfunction

   function automatic tick_type released_tick(int unsigned thr);
      tick_type t;
      t.armed  = 1'b0;
      t.sample = 12'($urandom_range(4095, thr + 1));
      return t;
   endfunction

   // Queue n pressed or released ticks, with the odd armed tick slipped in
   task automatic push_run(int n, int unsigned thr, bit press);
      tick_type t;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(15, 0) == 0) begin
            t.armed  = 1'b1;
            t.sample = 12'($urandom_range(4095, 0));
            tick_backlog.push_back(t);
         end
         tick_backlog.push_back(press ? pressed_tick(thr) : released_tick(thr));
      end
   endtask

   // One pass through all windows; a broken walk may skip the holding presses
   task automatic queue_walk(int unsigned thr, bit intact);
      push_run($urandom_range(3, 1), thr, 1'b1);
      push_run($urandom_range(38, 32), thr, 1'b0);
      if (intact || $urandom_range(1, 0))
         push_run($urandom_range(3, 1), thr, 1'b1);
      push_run($urandom_range(36, 30), thr, 1'b0);
      if (intact || $urandom_range(1, 0))
         push_run($urandom_range(3, 1), thr, 1'b1);
      push_run($urandom_range(98, 92), thr, 1'b0);
      push_run($urandom_range(2, 1), thr, 1'b1);
   endtask

   task automatic queue_noise(int n);
      tick_type t;
      repeat (n) begin
         t.armed  = 1'($urandom_range(1, 0));
         t.sample = 12'($urandom_range(4095, 0));
         tick_backlog.push_back(t);
      end
   endtask

   task automatic note_mismatch(string what, logic [7:0] want, logic [7:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch on indication %0d, %s: expected %0h, got %0h",
                  indications_checked, what, want, got);
   endtask

   // Write one register; csr_valid is left high so a following write runs on
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      case (idx)
         CSR_BUTTON_ENABLED:  arm_cfg.button_enabled  = value[0];
         CSR_AIRFRAME_KIND:   arm_cfg.airframe_kind   = value[1:0];
         CSR_PRESS_THRESHOLD: arm_cfg.press_threshold = value[11:0];
         CSR_REFUSE_PATTERN:  arm_cfg.refuse_pattern  = value;
         CSR_INIT_PATTERN:    arm_cfg.init_pattern    = value;
         CSR_SAFE_PATTERN:    arm_cfg.safe_pattern    = value;
         default: ;
      endcase
   endtask

   // Program every register; unused upper data bits carry junk
   task automatic program_sequencer(logic en, logic [1:0] air, logic [11:0] thr,
                                    logic [15:0] refuse, logic [15:0] init_p,
                                    logic [15:0] safe_p);
      logic [CSR_DATA_W-1:0] junk;
      junk = 16'($urandom);
      write_reg(CSR_BUTTON_ENABLED, {junk[15:1], en});
      write_reg(CSR_AIRFRAME_KIND, {junk[15:2], air});
      write_reg(CSR_PRESS_THRESHOLD, {junk[15:12], thr});
      write_reg(CSR_REFUSE_PATTERN, refuse);
      write_reg(CSR_INIT_PATTERN, init_p);
      write_reg(CSR_SAFE_PATTERN, safe_p);
      csr_valid <= 1'b0;
   endtask

   // Wait until every tick is taken and every indication has come back;
   // look between edges so that updates of the last edge have landed
   task automatic settle();
      do @(negedge clock);
      while (tick_backlog.size() != 0 || req_tvalid || awaited_indications.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Tick driver: hold an offered tick until its transaction completes
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_indications.push_back(sequencer_step(shown_tick));
            ticks_accepted++;
         end
         offer = req_tvalid && !req_tready;
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (tick_backlog.size() > 0) begin
               if (!calm && $urandom_range(9, 0) == 0) begin
                  send_gap = $urandom_range(10, 0);
               end else begin
                  shown_tick = tick_backlog.pop_front();
                  offer = 1'b1;
                  req_tdata <= {3'b000, shown_tick.armed, shown_tick.sample};
               end
            end
         end
         req_tvalid <= offer;
      end
   end

   // Result receiver: random stalls, plus one long hold-off to back the block up
   always @(posedge clock) begin
      logic take;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         take = 1'b0;
         if (hold_left > 0) begin
            hold_left--;
         end else if (!long_hold_done && ticks_accepted >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES - 1;
         end else if (recv_gap > 0) begin
            recv_gap--;
         end else if (!calm && $urandom_range(9, 0) == 0) begin
            recv_gap = $urandom_range(10, 0);
         end else begin
            take = 1'b1;
         end
         rsp_tready <= take;
      end
   end

   // Compare each result transaction with the oldest awaited indication
   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = result_type'(rsp_tdata[5:0]);
         if (awaited_indications.size() == 0) begin
            note_mismatch("indication with none awaited", 8'h00, rsp_tdata);
         end else begin
            want = awaited_indications.pop_front();
            if (seen.led_on !== want.led_on)
               note_mismatch("led_on", 8'(want.led_on), 8'(seen.led_on));
            if (seen.beep_event !== want.beep_event)
               note_mismatch("beep_event", 8'(want.beep_event), 8'(seen.beep_event));
            if (seen.motor_command !== want.motor_command)
               note_mismatch("motor_command", 8'(want.motor_command),
                             8'(seen.motor_command));
            if (seen.safe_to_output !== want.safe_to_output)
               note_mismatch("safe_to_output", 8'(want.safe_to_output),
                             8'(seen.safe_to_output));
            if (rsp_tdata[7:6] !== 2'b00)
               note_mismatch("padding", 8'h00, 8'(rsp_tdata[7:6]));
         end
         indications_checked++;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Defaults after reset: button off, indications report safe
      tick_backlog.push_back(tick_type'{1'b0, 12'h000});
      tick_backlog.push_back(tick_type'{1'b0, 12'hFFF});
      tick_backlog.push_back(tick_type'{1'b1, 12'h200});
      settle();

      // Directed ticks around the threshold and the armed freeze
      write_reg(CSR_SPARE_INDEX, 16'($urandom));
      program_sequencer(1'b1, AIRFRAME_AIRPLANE, PRESS_THRESHOLD_RESET,
                        16'hFFFF, 16'h0000, 16'hA5A5);
      tick_backlog.push_back(tick_type'{1'b0, 12'h000});
      tick_backlog.push_back(tick_type'{1'b0, 12'h200});
      tick_backlog.push_back(tick_type'{1'b0, 12'h201});
      tick_backlog.push_back(tick_type'{1'b0, 12'hFFF});
      tick_backlog.push_back(tick_type'{1'b1, 12'h000});
      tick_backlog.push_back(tick_type'{1'b1, 12'hFFF});
      tick_backlog.push_back(tick_type'{1'b0, 12'h555});
      tick_backlog.push_back(tick_type'{1'b0, 12'hAAA});
      tick_backlog.push_back(tick_type'{1'b1, 12'h1FF});
      tick_backlog.push_back(tick_type'{1'b0, 12'h800});
      push_run(10, PRESS_THRESHOLD_RESET, 1'b0);
      settle();

      // Full walk, multirotor, mid threshold, random patterns
      program_sequencer(1'b1, AIRFRAME_MULTIROTOR, 12'($urandom_range(3900, 100)),
                        16'($urandom), 16'($urandom), 16'($urandom));
      queue_walk(int'(arm_cfg.press_threshold), 1'b1);
      settle();

      // Full walk, airplane, only a zero sample counts as a press
      program_sequencer(1'b1, AIRFRAME_AIRPLANE, 12'h000, 16'hFFFF, 16'h0000, 16'hFFFF);
      queue_walk(0, 1'b1);
      settle();

      // Noise with the button off, then with every sample a press and no airframe
      program_sequencer(1'b0, AIRFRAME_NONE, 12'hFFF,
                        16'($urandom), 16'($urandom), 16'($urandom));
      queue_noise(20);
      settle();
      program_sequencer(1'b1, AIRFRAME_NONE, 12'hFFF,
                        16'($urandom), 16'($urandom), 16'($urandom));
      queue_noise(20);
      settle();

      // Last part runs back to back: unknown airframe, release only at full scale
      calm = 1'b1;
      program_sequencer(1'b1, AIRFRAME_UNKNOWN, 12'd4094,
                        16'($urandom), 16'($urandom), 16'($urandom));
      queue_walk(4094, 1'($urandom_range(1, 0)));
      settle();

      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
